[rtl/core/cpio_pkg.sv]
// shared types, constants and decode helpers for the cpio newc stream walker
// used by cpio_out_fifo and cpio_newc_stream_walker; no dependencies
package cpio_pkg;

  localparam int unsigned HEX_DIGITS = 8;

  localparam logic [6:0] HDR_LEN   = 7'd110;
  localparam logic [6:0] MAGIC_LEN = 7'd6;
  localparam logic [6:0] FSIZE_OFF = 7'd54;
  localparam logic [6:0] NSIZE_OFF = 7'd94;
  localparam logic [6:0] FSIZE_END = FSIZE_OFF + 7'(HEX_DIGITS);
  localparam logic [6:0] NSIZE_END = NSIZE_OFF + 7'(HEX_DIGITS);

  localparam logic [7:0] LF_CHAR = 8'd10;
  localparam logic [7:0] CR_CHAR = 8'd13;

  // output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_CRLF_EXPAND = 1'b0;
  localparam logic CFG_STOP_AT_NUL = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_DATA,
    PH_DATA_PAD,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  // up to two result words per accepted input word
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

  // "070701"
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/cpio_out_fifo.sv]
// four-word result queue with a two-word push port and a stream read side
// depends on cpio_pkg
module cpio_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpio_pkg::push_t   push_i,
  output logic              room_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output cpio_pkg::res_t    m_res_o
);

  cpio_pkg::res_t mem_q [cpio_pkg::FIFO_DEPTH];

  logic [cpio_pkg::FIFO_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [cpio_pkg::FIFO_CW-1:0] cnt_q, cnt_d;
  logic                         pop;
  logic [cpio_pkg::FIFO_CW-1:0] n_push;

  assign m_valid_o = (cnt_q != '0);
  assign pop       = m_valid_o & m_ready_i;
  assign m_res_o   = mem_q[rptr_q];
  // room for a worst-case push of two words
  assign room_o    = (cnt_q <= cpio_pkg::FIFO_CW'(cpio_pkg::FIFO_DEPTH - 2));

  always_comb begin
    n_push = cpio_pkg::FIFO_CW'(push_i.v0) + cpio_pkg::FIFO_CW'(push_i.v1);
    wptr_d = wptr_q + cpio_pkg::FIFO_AW'(n_push);
    rptr_d = rptr_q + cpio_pkg::FIFO_AW'(pop);
    cnt_d  = cnt_q + n_push - cpio_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wptr_q + cpio_pkg::FIFO_AW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/cpio_newc_stream_walker.sv]
// top level: walks a cpio newc archive and streams out name and data words
// depends on cpio_pkg and cpio_out_fifo
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid_i/tready_o       tdata = archive byte
//  m_axis    out  m_axis_tvalid_o/tready_i       tdata = byte, tuser = kind, tlast
//  cfg       in   cfg_we_i (no wait)             cfg_idx_i selects, cfg_wdata_i
//
// one input word per cycle, decoded against the walker state as it is accepted;
// its results enter a four-word queue and are offered from the next cycle
// an expanded lf gives two words, so the queue grows by one per expanded lf even
// with the output always ready; input stalls while three or more words wait
// (a second expanded lf before the queue drains, or the output side holding off)
// async active-low reset: walker at a header start, both options set, queue empty
module cpio_newc_stream_walker (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i
);

  cpio_pkg::phase_e phase_q, phase_d;
  logic [6:0]       hc_q, hc_d;
  logic [31:0]      nsize_q, nsize_d;
  logic [31:0]      fsize_q, fsize_d;
  logic [31:0]      run_q, run_d;
  logic             magic_ok_q, magic_ok_d;
  logic             nul_seen_q, nul_seen_d;
  logic             crlf_q, stop_nul_q;

  logic             room, accept;
  logic [7:0]       b;
  logic             mok_now;
  logic [31:0]      run_inc;
  logic [1:0]       pad;
  cpio_pkg::push_t  push;
  cpio_pkg::res_t   m_res;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i & room;
  assign run_inc         = run_q + 32'd1;

  always_comb begin
    phase_d    = phase_q;
    hc_d       = hc_q;
    nsize_d    = nsize_q;
    fsize_d    = fsize_q;
    run_d      = run_q;
    magic_ok_d = magic_ok_q;
    nul_seen_d = nul_seen_q;
    mok_now    = 1'b1;
    pad        = 2'd0;
    push       = '0;

    if (accept) begin
      case (phase_q)
        cpio_pkg::PH_HEADER: begin
          // a new header clears the sizes and rearms the magic check
          if (hc_q == '0) begin
            nsize_d = '0;
            fsize_d = '0;
            mok_now = 1'b1;
          end else begin
            mok_now = magic_ok_q;
          end
          if (hc_q < cpio_pkg::MAGIC_LEN && b != cpio_pkg::magic_char(hc_q[2:0])) begin
            mok_now = 1'b0;
          end
          magic_ok_d = mok_now;
          if (hc_q >= cpio_pkg::FSIZE_OFF && hc_q < cpio_pkg::FSIZE_END) begin
            fsize_d = {fsize_q[27:0], cpio_pkg::hex_value(b)};
          end
          if (hc_q >= cpio_pkg::NSIZE_OFF && hc_q < cpio_pkg::NSIZE_END) begin
            nsize_d = {nsize_q[27:0], cpio_pkg::hex_value(b)};
          end
          hc_d = hc_q + 7'd1;
          if (hc_q == cpio_pkg::MAGIC_LEN - 7'd1 && !mok_now) begin
            // bad magic: one end word, then ignore the rest
            push.v0      = 1'b1;
            push.r0.data = '0;
            push.r0.kind = cpio_pkg::KIND_END;
            push.r0.last = 1'b0;
            phase_d      = cpio_pkg::PH_DONE;
            hc_d         = '0;
          end else if (hc_q == cpio_pkg::HDR_LEN - 7'd1) begin
            hc_d  = '0;
            run_d = '0;
            if (nsize_q == '0) begin
              // empty name: straight to the header+name padding
              pad = 2'(2'd0 - (nsize_q[1:0] + 2'd2));
              if (pad != 2'd0) begin
                phase_d = cpio_pkg::PH_NAME_PAD;
                run_d   = 32'(pad);
              end else begin
                nul_seen_d = 1'b0;
                phase_d    = (fsize_d != '0) ? cpio_pkg::PH_DATA : cpio_pkg::PH_HEADER;
              end
            end else begin
              phase_d = cpio_pkg::PH_NAME;
            end
          end
        end

        cpio_pkg::PH_NAME: begin
          // the byte at the final position is the terminator and is dropped
          if (run_inc != nsize_q) begin
            push.v0      = 1'b1;
            push.r0.data = b;
            push.r0.kind = cpio_pkg::KIND_NAME;
            push.r0.last = ((run_q + 32'd2) == nsize_q);
          end
          run_d = run_inc;
          if (run_inc == nsize_q) begin
            pad = 2'(2'd0 - (nsize_q[1:0] + 2'd2));
            if (pad != 2'd0) begin
              phase_d = cpio_pkg::PH_NAME_PAD;
              run_d   = 32'(pad);
            end else begin
              run_d      = '0;
              nul_seen_d = 1'b0;
              hc_d       = '0;
              phase_d    = (fsize_q != '0) ? cpio_pkg::PH_DATA : cpio_pkg::PH_HEADER;
            end
          end
        end

        cpio_pkg::PH_NAME_PAD: begin
          run_d = run_q - 32'd1;
          if (run_q[1:0] == 2'd1) begin
            run_d      = '0;
            nul_seen_d = 1'b0;
            hc_d       = '0;
            phase_d    = (fsize_q != '0) ? cpio_pkg::PH_DATA : cpio_pkg::PH_HEADER;
          end
        end

        cpio_pkg::PH_DATA: begin
          if (!nul_seen_q) begin
            if (b == '0 && stop_nul_q) begin
              nul_seen_d = 1'b1;
            end else if (b == cpio_pkg::LF_CHAR && crlf_q) begin
              push.v0      = 1'b1;
              push.r0.data = cpio_pkg::CR_CHAR;
              push.r0.kind = cpio_pkg::KIND_DATA;
              push.r0.last = 1'b0;
              push.v1      = 1'b1;
              push.r1.data = b;
              push.r1.kind = cpio_pkg::KIND_DATA;
              push.r1.last = (run_inc == fsize_q);
            end else begin
              push.v0      = 1'b1;
              push.r0.data = b;
              push.r0.kind = cpio_pkg::KIND_DATA;
              push.r0.last = (run_inc == fsize_q);
            end
          end
          run_d = run_inc;
          if (run_inc == fsize_q) begin
            pad  = 2'(2'd0 - fsize_q[1:0]);
            hc_d = '0;
            if (pad != 2'd0) begin
              phase_d = cpio_pkg::PH_DATA_PAD;
              run_d   = 32'(pad);
            end else begin
              phase_d = cpio_pkg::PH_HEADER;
            end
          end
        end

        cpio_pkg::PH_DATA_PAD: begin
          run_d = run_q - 32'd1;
          if (run_q[1:0] == 2'd1) begin
            hc_d    = '0;
            phase_d = cpio_pkg::PH_HEADER;
          end
        end

        default: begin
          // done: every byte is swallowed
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cpio_pkg::PH_HEADER;
      hc_q       <= '0;
      nsize_q    <= '0;
      fsize_q    <= '0;
      run_q      <= '0;
      magic_ok_q <= 1'b1;
      nul_seen_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hc_q       <= hc_d;
      nsize_q    <= nsize_d;
      fsize_q    <= fsize_d;
      run_q      <= run_d;
      magic_ok_q <= magic_ok_d;
      nul_seen_q <= nul_seen_d;
    end
  end

  // option registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crlf_q     <= 1'b1;
      stop_nul_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpio_pkg::CFG_CRLF_EXPAND: crlf_q     <= cfg_wdata_i;
        cpio_pkg::CFG_STOP_AT_NUL: stop_nul_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cpio_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = m_res.data;
  assign m_axis_tuser_o = m_res.kind;
  assign m_axis_tlast_o = m_res.last;

endmodule

[sim/cpio_walk_checker.sv]
`timescale 1ns / 100ps
// checker for the cpio newc stream walker: follows every accepted archive word,
// predicts the output words and compares them in order; depends on cpio_pkg
module cpio_walk_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_data_i,
  input  logic [1:0] out_kind_i,
  input  logic       out_last_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i,
  output int         fail_count_o,
  output int         words_due_o
);

  localparam logic [47:0] NEWC_MAGIC = "070701";

  cpio_pkg::res_t   due_words[$];

  cpio_pkg::phase_e walk_phase;
  logic [6:0]       hdr_pos;
  logic [31:0]      nsize;
  logic [31:0]      fsize;
  logic [31:0]      run_cnt;
  logic             magic_good;
  logic             cut_by_nul;
  logic             crlf_on;
  logic             nul_stop;

  function automatic logic [31:0] digit_of(input logic [7:0] c);
    logic [31:0] d;
    d = 32'd0;
    if (c >= "0" && c <= "9") begin
      d = 32'(c) - 32'h30;
    end else if (c >= "A" && c <= "F") begin
      d = 32'(c) - 32'h37;
    end
    return d;
  endfunction

  task automatic push_word(input logic [7:0] d, input cpio_pkg::kind_e k, input logic l);
    cpio_pkg::res_t w;
    w.data = d;
    w.kind = k;
    w.last = l;
    due_words.push_back(w);
  endtask

  task automatic start_data();
    run_cnt    = 32'd0;
    cut_by_nul = 1'b0;
    hdr_pos    = 7'd0;
    walk_phase = (fsize != 32'd0) ? cpio_pkg::PH_DATA : cpio_pkg::PH_HEADER;
  endtask

  // header plus name is padded to four bytes
  task automatic finish_name();
    logic [31:0] pad;
    pad = (32'd0 - (32'd2 + nsize)) & 32'd3;
    if (pad != 32'd0) begin
      walk_phase = cpio_pkg::PH_NAME_PAD;
      run_cnt    = pad;
    end else begin
      start_data();
    end
  endtask

  task automatic walk_byte(input logic [7:0] b);
    logic [6:0]  pos;
    logic [31:0] pad;
    logic        at_end;
    case (walk_phase)
      cpio_pkg::PH_HEADER: begin
        pos = hdr_pos;
        if (pos == 7'd0) begin
          magic_good = 1'b1;
          nsize      = 32'd0;
          fsize      = 32'd0;
        end
        if (pos < cpio_pkg::MAGIC_LEN) begin
          if (b != NEWC_MAGIC[8 * (5 - int'(pos)) +: 8]) magic_good = 1'b0;
        end
        if (pos >= cpio_pkg::FSIZE_OFF && pos < cpio_pkg::FSIZE_END) begin
          fsize = (fsize << 4) + digit_of(b);
        end
        if (pos >= cpio_pkg::NSIZE_OFF && pos < cpio_pkg::NSIZE_END) begin
          nsize = (nsize << 4) + digit_of(b);
        end
        hdr_pos = pos + 7'd1;
        if (pos == cpio_pkg::MAGIC_LEN - 7'd1 && !magic_good) begin
          push_word(8'd0, cpio_pkg::KIND_END, 1'b0);
          walk_phase = cpio_pkg::PH_DONE;
          hdr_pos    = 7'd0;
        end else if (hdr_pos >= cpio_pkg::HDR_LEN) begin
          hdr_pos = 7'd0;
          run_cnt = 32'd0;
          if (nsize == 32'd0) finish_name();
          else walk_phase = cpio_pkg::PH_NAME;
        end
      end
      cpio_pkg::PH_NAME: begin
        // the final name byte is the terminator and is dropped whatever it holds
        if (run_cnt < nsize - 32'd1) begin
          push_word(b, cpio_pkg::KIND_NAME, run_cnt + 32'd2 == nsize);
        end
        run_cnt = run_cnt + 32'd1;
        if (run_cnt >= nsize) finish_name();
      end
      cpio_pkg::PH_NAME_PAD: begin
        run_cnt = run_cnt - 32'd1;
        if (run_cnt == 32'd0) start_data();
      end
      cpio_pkg::PH_DATA: begin
        at_end = (run_cnt == fsize - 32'd1);
        if (!cut_by_nul) begin
          if (b == 8'd0 && nul_stop) begin
            cut_by_nul = 1'b1;
          end else begin
            if (b == cpio_pkg::LF_CHAR && crlf_on) begin
              push_word(cpio_pkg::CR_CHAR, cpio_pkg::KIND_DATA, 1'b0);
            end
            push_word(b, cpio_pkg::KIND_DATA, at_end);
          end
        end
        run_cnt = run_cnt + 32'd1;
        if (run_cnt >= fsize) begin
          pad     = (32'd0 - fsize) & 32'd3;
          hdr_pos = 7'd0;
          if (pad != 32'd0) begin
            walk_phase = cpio_pkg::PH_DATA_PAD;
            run_cnt    = pad;
          end else begin
            walk_phase = cpio_pkg::PH_HEADER;
          end
        end
      end
      cpio_pkg::PH_DATA_PAD: begin
        run_cnt = run_cnt - 32'd1;
        if (run_cnt == 32'd0) begin
          hdr_pos    = 7'd0;
          walk_phase = cpio_pkg::PH_HEADER;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cpio_pkg::res_t exp_w;
    if (!rst_ni) begin
      due_words.delete();
      walk_phase   = cpio_pkg::PH_HEADER;
      hdr_pos      = 7'd0;
      nsize        = 32'd0;
      fsize        = 32'd0;
      run_cnt      = 32'd0;
      magic_good   = 1'b1;
      cut_by_nul   = 1'b0;
      crlf_on      = 1'b1;
      nul_stop     = 1'b1;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cpio_pkg::CFG_CRLF_EXPAND: crlf_on  = cfg_wdata_i;
          cpio_pkg::CFG_STOP_AT_NUL: nul_stop = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      // predict first so a same-cycle output word still finds its expectation
      if (in_valid_i && in_ready_i) walk_byte(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got data %h kind %0d last %0d",
                   $time, out_data_i, out_kind_i, out_last_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_w = due_words.pop_front();
          if (out_data_i !== exp_w.data || out_kind_i !== exp_w.kind ||
              out_last_i !== exp_w.last) begin
            $display({"%0t: mismatch, expected data %h kind %0d last %0d,",
                      " got data %h kind %0d last %0d"},
                     $time, exp_w.data, exp_w.kind, exp_w.last,
                     out_data_i, out_kind_i, out_last_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
    end
    words_due_o = due_words.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// top of the cpio newc stream walker testbench: builds archives, drives the
// byte stream, the output backpressure and the option writes, and gives the
// verdict; depends on cpio_pkg, cpio_walk_checker and cpio_newc_stream_walker
module tb;

  localparam logic [47:0] NEWC_MAGIC = "070701";
  // cycles the walker may still need after the last expected word
  localparam int SETTLE = 8;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_data   = 8'd0;
  logic       out_ready = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_idx   = 1'b0;
  logic       cfg_wdata = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_data;
  logic [1:0] out_kind;
  logic       out_last;
  int         fail_count;
  int         words_due;

  // steady: no more idling on either side; stall_req asks the receiver for
  // one long hold-off while the sender keeps pushing
  bit         steady     = 1'b0;
  bit         stall_req  = 1'b0;
  bit         stall_done = 1'b0;
  int         bytes_sent = 0;

  logic [7:0] arch_q[$];     // archive bytes waiting to go out
  logic [7:0] name_buf[$];   // name of the next entry, terminator included
  logic [7:0] data_buf[$];   // file body of the next entry

  cpio_newc_stream_walker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_kind),
    .m_axis_tlast_o  (out_last),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  cpio_walk_checker walk_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .out_kind_i   (out_kind),
    .out_last_i   (out_last),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // single reset at the start
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5000000;
    $display("tb failed");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request, then always ready
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        out_ready  <= 1'b0;
        stall_done  = 1'b1;
        repeat (400) @(negedge clk);
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one word, called and returning at a falling edge; valid stays high
  // between back-to-back words
  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent = bytes_sent + 1;
    @(negedge clk);
  endtask

  task automatic send_queued(input int count);
    repeat (count) send_byte(arch_q.pop_front());
  endtask

  // stop offering and let every expected word drain before touching options
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // eight upper-case hex digits; a noisy digit becomes a non-hex character,
  // which the walker counts as zero, so eff is what it will decode
  task automatic push_hex(input int unsigned val, input bit noisy,
                          output int unsigned eff);
    logic [3:0] d;
    logic [7:0] c;
    eff = 0;
    for (int k = 7; k >= 0; k--) begin
      d = 4'((val >> (4 * k)) & 32'hF);
      if (noisy && $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          c = 8'($urandom_range(8'h61, 8'h66));   // lower case a..f
        end else begin
          c = 8'($urandom);
          while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F")) c = 8'($urandom);
        end
        d = 4'd0;
      end else begin
        c = (d < 4'd10) ? 8'h30 + 8'(d) : 8'h37 + 8'(d);
      end
      eff = (eff << 4) + d;
      arch_q.push_back(c);
    end
  endtask

  // one newc entry from name_buf and data_buf; with noise the decoded sizes
  // shrink and only their leading bytes go out
  task automatic add_entry(input bit noisy);
    int unsigned ns_e;
    int unsigned fs_e;
    for (int i = 0; i < 6; i++) arch_q.push_back(NEWC_MAGIC[8 * (5 - i) +: 8]);
    repeat (48) arch_q.push_back(8'($urandom));     // ino .. mtime
    push_hex(data_buf.size(), noisy, fs_e);
    repeat (32) arch_q.push_back(8'($urandom));     // device numbers
    push_hex(name_buf.size(), noisy, ns_e);
    repeat (8) arch_q.push_back(8'($urandom));      // check field
    for (int i = 0; i < ns_e; i++) arch_q.push_back(name_buf[i]);
    repeat ((4 - ((ns_e + 2) % 4)) % 4) arch_q.push_back(8'($urandom));
    for (int i = 0; i < fs_e; i++) arch_q.push_back(data_buf[i]);
    repeat ((4 - (fs_e % 4)) % 4) arch_q.push_back(8'($urandom));
  endtask

  task automatic set_name(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    name_buf.push_back(8'd0);
  endtask

  task automatic fill_name(input int n);
    name_buf.delete();
    repeat (n) name_buf.push_back(8'($urandom));
  endtask

  // text bodies carry plenty of line feeds and the odd nul
  task automatic fill_data(input int n, input bit text);
    int r;
    data_buf.delete();
    repeat (n) begin
      r = $urandom_range(0, 15);
      if (text && r < 2) data_buf.push_back(cpio_pkg::LF_CHAR);
      else if (text && r == 2) data_buf.push_back(8'd0);
      else data_buf.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    int target;
    int ns;
    int fs;
    int k;
    bit first;

    wait (rst_n);
    @(negedge clk);

    // ---- directed part, options at their reset values ----
    // empty file, a one-character name that needs no padding
    set_name("a");
    data_buf.delete();
    add_entry(1'b0);
    // zero name size: no name words, two pad bytes
    name_buf.delete();
    data_buf = '{8'h68, 8'h69, 8'h0a, 8'h78, 8'h0a};
    add_entry(1'b0);
    // name of size one: only the terminator
    name_buf = '{8'h00};
    fill_data(4, 1'b1);
    add_entry(1'b0);
    // nul inside the name is passed on, the final byte dropped though not nul
    name_buf = '{8'h78, 8'h00, 8'h79, 8'h5a};
    data_buf = '{8'h6f, 8'h6b, 8'h0a};
    add_entry(1'b0);
    // nul cuts the rest of the body, no last flag on that run
    set_name("cut");
    data_buf = '{8'h61, 8'h62, 8'h00, 8'h63, 8'h0a, 8'h64};
    add_entry(1'b0);
    // non-hex characters in the size digits count as zero
    set_name("noisy.txt");
    fill_data(20, 1'b1);
    add_entry(1'b1);
    // trailer is just another entry
    set_name("TRAILER!!!");
    data_buf.delete();
    add_entry(1'b0);
    send_queued(arch_q.size());

    // every byte value with expansion on and nul cut off
    wait_quiet();
    write_cfg(cpio_pkg::CFG_STOP_AT_NUL, 1'b0);
    set_name("bytes");
    data_buf.delete();
    for (int i = 0; i < 256; i++) data_buf.push_back(8'(i));
    add_entry(1'b0);
    send_queued(arch_q.size());

    // both options off
    wait_quiet();
    write_cfg(cpio_pkg::CFG_CRLF_EXPAND, 1'b0);
    fill_name(7);
    fill_data(30, 1'b1);
    add_entry(1'b0);
    send_queued(arch_q.size());

    // nul cut without expansion, then the cut option cleared mid-body:
    // suppression holds
    wait_quiet();
    write_cfg(cpio_pkg::CFG_STOP_AT_NUL, 1'b1);
    set_name("ab");
    data_buf = '{8'h78, 8'h00, 8'h79, 8'h79, 8'h0a, 8'h7a};
    add_entry(1'b0);
    send_queued(arch_q.size() - 6);   // stop right after the nul
    wait_quiet();
    write_cfg(cpio_pkg::CFG_STOP_AT_NUL, 1'b0);
    send_queued(arch_q.size());

    // ---- random part: mostly well-formed entries, some with noisy sizes ----
    stall_req = 1'b1;
    target    = bytes_sent + 150;
    first     = 1'b1;
    while (bytes_sent < target) begin
      if (!first && $urandom_range(0, 3) == 0) begin
        wait_quiet();
        write_cfg(cpio_pkg::CFG_CRLF_EXPAND, 1'($urandom));
        write_cfg(cpio_pkg::CFG_STOP_AT_NUL, 1'($urandom));
      end
      case ($urandom_range(0, 9))
        0:       ns = 0;
        1:       ns = 1;
        2:       ns = 2;
        default: ns = $urandom_range(3, 20);
      endcase
      case ($urandom_range(0, 9))
        0:       fs = 0;
        9:       fs = $urandom_range(100, 300);
        default: fs = $urandom_range(1, 60);
      endcase
      // the first body is long enough to back the walker up during the hold-off
      if (first) fs = $urandom_range(64, 120);
      fill_name(ns);
      fill_data(fs, $urandom_range(0, 3) != 0);
      add_entry($urandom_range(0, 7) == 0);
      if (bytes_sent > target - 350) steady = 1'b1;
      send_queued(arch_q.size());
      first = 1'b0;
    end
    steady = 1'b1;

    // ---- bad magic ends the archive for good; trailing bytes are ignored ----
    k = $urandom_range(0, 5);
    for (int i = 0; i < k; i++) arch_q.push_back(NEWC_MAGIC[8 * (5 - i) +: 8]);
    arch_q.push_back(NEWC_MAGIC[8 * (5 - k) +: 8] ^ 8'($urandom_range(1, 255)));
    repeat (40) arch_q.push_back(8'($urandom));
    send_queued(arch_q.size());

    wait_quiet();
    repeat (2 * SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
